// ===== rtl/ordered_sequenced_reorder_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// Reorder buffer assertion macros
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SEQUENCED_REORDER_BUFFER_DEFINES_SVH
`define ORDERED_SEQUENCED_REORDER_BUFFER_DEFINES_SVH

`ifndef SYNTH
`define OSRB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("reorder buffer check failed");
`define OSRB_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("reorder buffer forbidden condition seen");
`else
`define OSRB_ASSERT(label, prop)
`define OSRB_NEVER(label, cond)
`endif

`endif

// ===== rtl/osrb_pkg.sv =====
// ----------------------------------------------------------------------------
// osrb_pkg
// Shared types and constants of the per-channel reorder buffer.
// ----------------------------------------------------------------------------
package osrb_pkg;

  localparam int OSRB_CHANNELS    = 8;
  localparam int OSRB_WINDOW      = 32;
  localparam int OSRB_HANDLE_BITS = 16;

  localparam int HANDLE_W     = 16;
  localparam int CHAN_FIELD_W = 3;
  localparam int INDEX_W      = 32;
  localparam int MODE_W       = 2;
  localparam int KIND_W       = 2;
  // covers the largest slot store over the whole parameter range (256 x 64)
  localparam int CMD_ADDR_W   = 14;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_UNORDERED = 2'd0,
    MODE_SEQUENCED = 2'd1,
    MODE_ORDERED   = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVERED = 2'd0,
    KIND_LATE      = 2'd1,
    KIND_HELD      = 2'd2,
    KIND_DROPPED   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_EMIT  = 2'd0,
    OP_HOLD  = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [CMD_ADDR_W-1:0]   addr;
    logic [HANDLE_W-1:0]     handle;
    kind_t                   kind;
    logic [CHAN_FIELD_W-1:0] channel;
    logic                    last;
  } cmd_t;

endpackage

// ===== rtl/osrb_front.sv =====
// ----------------------------------------------------------------------------
// osrb_front
// Classifies packets against per-channel state and walks held runs.
// ----------------------------------------------------------------------------
`include "ordered_sequenced_reorder_buffer_defines.svh"

module osrb_front import osrb_pkg::*; #(
  parameter int CHANNELS    = OSRB_CHANNELS,
  parameter int WINDOW      = OSRB_WINDOW,
  parameter int HANDLE_BITS = OSRB_HANDLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [HANDLE_W-1:0]     in_handle,
  input  logic [CHAN_FIELD_W-1:0] in_channel,
  input  logic [INDEX_W-1:0]      in_order_index,
  input  logic [MODE_W-1:0]       in_mode,
  output logic                    cmd_push,
  output cmd_t                    cmd,
  input  logic                    q_full
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SL_W   = $clog2(WINDOW);
  localparam int ADDR_W = (CHANNELS * WINDOW > 1) ? $clog2(CHANNELS * WINDOW) : 1;
  localparam int HW     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [INDEX_W-1:0]      rd_idx_r  [CHANNELS];
  logic [INDEX_W-1:0]      exp_idx_r [CHANNELS];
  logic [SL_W-1:0]         head_r    [CHANNELS];
  logic [WINDOW-1:0]       occ_r     [CHANNELS];
  logic [CH_W-1:0]         wch_r, wch_nxt;
  logic [CHAN_FIELD_W-1:0] wchf_r, wchf_nxt;
  logic [SL_W-1:0]         walk_i_r, walk_i_nxt;

  logic [CH_W-1:0]    ch_in, sel_ch;
  logic [INDEX_W-1:0] cur_rd, cur_exp, off;
  logic [SL_W-1:0]    cur_head, nh, slot;
  logic [SL_W:0]      slot_sum;
  logic [WINDOW-1:0]  cur_occ;
  logic               accept, walk_last;
  logic               rd_wr, exp_wr, head_wr, occ_wr;
  logic [INDEX_W-1:0] rd_nxt, exp_nxt;
  logic [SL_W-1:0]    head_nxt;
  logic [WINDOW-1:0]  occ_nxt;

  function automatic logic [CH_W-1:0] ch_mod(input logic [CHAN_FIELD_W-1:0] c);
    logic [CHAN_FIELD_W:0] v;
    v = {1'b0, c};
    for (int i = 0; i < (1 << CHAN_FIELD_W); i++) begin
      if (int'(v) >= CHANNELS) v = v - (CHAN_FIELD_W+1)'(CHANNELS);
    end
    return CH_W'(v);
  endfunction

  function automatic logic [SL_W-1:0] next_slot(input logic [SL_W-1:0] s);
    return (int'(s) == WINDOW - 1) ? '0 : s + SL_W'(1);
  endfunction

  function automatic logic [CMD_ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] c,
                                                      input logic [SL_W-1:0] s);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(c) * ADDR_W'(WINDOW) + ADDR_W'(s);
    return CMD_ADDR_W'(a);
  endfunction

  assign ch_in    = ch_mod(in_channel);
  assign sel_ch   = (state_r == ST_WALK) ? wch_r : ch_in;
  assign cur_rd   = rd_idx_r[sel_ch];
  assign cur_exp  = exp_idx_r[sel_ch];
  assign cur_head = head_r[sel_ch];
  assign cur_occ  = occ_r[sel_ch];
  assign off      = in_order_index - cur_rd;
  assign nh       = next_slot(cur_head);
  // off is below WINDOW here, so one subtract folds the ring position
  assign slot_sum = {1'b0, cur_head} + {1'b0, off[SL_W-1:0]};
  assign slot     = (int'(slot_sum) >= WINDOW) ? SL_W'(slot_sum - (SL_W+1)'(WINDOW))
                                               : slot_sum[SL_W-1:0];

  assign full      = (state_r != ST_IDLE) || q_full;
  assign accept    = push && !full;
  assign walk_last = (int'(walk_i_r) == WINDOW - 1) || !cur_occ[nh];

  always_comb begin
    state_nxt   = state_r;
    wch_nxt     = wch_r;
    wchf_nxt    = wchf_r;
    walk_i_nxt  = walk_i_r;
    rd_wr       = 1'b0;
    exp_wr      = 1'b0;
    head_wr     = 1'b0;
    occ_wr      = 1'b0;
    rd_nxt      = cur_rd + INDEX_W'(1);
    exp_nxt     = in_order_index + INDEX_W'(1);
    head_nxt    = nh;
    occ_nxt     = cur_occ;
    cmd_push    = 1'b0;
    cmd.op      = OP_EMIT;
    cmd.addr    = slot_addr(sel_ch, slot);
    cmd.handle  = HANDLE_W'(in_handle[HW-1:0]);
    cmd.kind    = KIND_DELIVERED;
    cmd.channel = in_channel;
    cmd.last    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_push = 1'b1;
          case (in_mode)
            MODE_SEQUENCED: begin
              if (in_order_index >= cur_exp) begin
                exp_wr = 1'b1;
              end else begin
                cmd.kind = KIND_LATE;
              end
            end
            MODE_ORDERED: begin
              if (in_order_index < cur_rd) begin
                cmd.kind = KIND_LATE;
              end else if (off >= INDEX_W'(WINDOW)) begin
                cmd.kind = KIND_DROPPED;
              end else if (off == '0) begin
                // in-order arrival: deliver, then drain any run held behind it
                rd_wr    = 1'b1;
                head_wr  = 1'b1;
                cmd.last = !cur_occ[nh];
                if (cur_occ[nh]) begin
                  state_nxt  = ST_WALK;
                  wch_nxt    = ch_in;
                  wchf_nxt   = in_channel;
                  walk_i_nxt = SL_W'(1);
                end
              end else if (cur_occ[slot]) begin
                cmd.kind = KIND_LATE;
              end else begin
                cmd.op        = OP_HOLD;
                cmd.kind      = KIND_HELD;
                occ_wr        = 1'b1;
                occ_nxt[slot] = 1'b1;
              end
            end
            default: begin
              cmd.kind = KIND_DELIVERED;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!q_full) begin
          cmd_push          = 1'b1;
          cmd.op            = OP_FETCH;
          cmd.addr          = slot_addr(wch_r, cur_head);
          cmd.handle        = '0;
          cmd.channel       = wchf_r;
          cmd.last          = walk_last;
          rd_wr             = 1'b1;
          head_wr           = 1'b1;
          occ_wr            = 1'b1;
          occ_nxt[cur_head] = 1'b0;
          walk_i_nxt        = walk_i_r + SL_W'(1);
          if (walk_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int c = 0; c < CHANNELS; c++) begin
        rd_idx_r[c]  <= '0;
        exp_idx_r[c] <= '0;
        head_r[c]    <= '0;
        occ_r[c]     <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (rd_wr)   rd_idx_r[sel_ch]  <= rd_nxt;
      if (exp_wr)  exp_idx_r[sel_ch] <= exp_nxt;
      if (head_wr) head_r[sel_ch]    <= head_nxt;
      if (occ_wr)  occ_r[sel_ch]     <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wch_r    <= wch_nxt;
    wchf_r   <= wchf_nxt;
    walk_i_r <= walk_i_nxt;
  end

  `OSRB_NEVER(a_push_room, cmd_push && q_full)
  `OSRB_ASSERT(a_walk_occ, (state_r == ST_WALK) |-> cur_occ[cur_head])
  `OSRB_ASSERT(a_walk_end, (state_r == ST_WALK && !q_full && walk_last) |=> (state_r == ST_IDLE))

endmodule

// ===== rtl/osrb_queue.sv =====
// ----------------------------------------------------------------------------
// osrb_queue
// Short command queue between the classifier and the delivery side.
// ----------------------------------------------------------------------------
module osrb_queue import osrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic q_full,
  output logic q_valid,
  input  logic rd_en,
  output cmd_t rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_data = store_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + CNT_W'(1);
    if (do_rd && !do_wr) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) store_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/osrb_back.sv =====
// ----------------------------------------------------------------------------
// osrb_back
// Executes queued commands: slot store writes and reads, result register.
// ----------------------------------------------------------------------------
module osrb_back import osrb_pkg::*; #(
  parameter int CHANNELS    = OSRB_CHANNELS,
  parameter int WINDOW      = OSRB_WINDOW,
  parameter int HANDLE_BITS = OSRB_HANDLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  cmd_t                    q_data,
  output logic                    q_take,
  output logic                    empty,
  input  logic                    pop,
  output logic [HANDLE_W-1:0]     out_handle,
  output logic [KIND_W-1:0]       out_kind,
  output logic [CHAN_FIELD_W-1:0] out_channel,
  output logic                    out_last
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  logic [HW-1:0]           slot_mem [DEPTH];
  logic [HW-1:0]           rdata_r;
  logic                    s1_valid_r;
  cmd_t                    s1_cmd_r;
  logic                    out_valid_r;
  logic [HANDLE_W-1:0]     out_handle_r;
  kind_t                   out_kind_r;
  logic [CHAN_FIELD_W-1:0] out_channel_r;
  logic                    out_last_r;
  logic                    out_adv;
  logic [ADDR_W-1:0]       addr;

  assign addr    = q_data.addr[ADDR_W-1:0];
  assign out_adv = s1_valid_r && (!out_valid_r || pop);
  assign q_take  = q_valid && (!s1_valid_r || out_adv);

  // read data lines up with the command as it enters the second stage
  always_ff @(posedge clk) begin
    if (q_take) begin
      if (q_data.op == OP_HOLD) slot_mem[addr] <= q_data.handle[HW-1:0];
      rdata_r  <= slot_mem[addr];
      s1_cmd_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_handle_r  <= (s1_cmd_r.op == OP_FETCH) ? HANDLE_W'(rdata_r) : s1_cmd_r.handle;
      out_kind_r    <= s1_cmd_r.kind;
      out_channel_r <= s1_cmd_r.channel;
      out_last_r    <= s1_cmd_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_take)       s1_valid_r <= 1'b1;
      else if (out_adv) s1_valid_r <= 1'b0;
      if (out_adv)      out_valid_r <= 1'b1;
      else if (pop)     out_valid_r <= 1'b0;
    end
  end

  assign empty       = !out_valid_r;
  assign out_handle  = out_handle_r;
  assign out_kind    = out_kind_r;
  assign out_channel = out_channel_r;
  assign out_last    = out_last_r;

endmodule

// ===== rtl/ordered_sequenced_reorder_buffer.sv =====
// Each result passes the command queue, the s1 stage and the output register in turn.
// Throughput: one word per cycle while each word causes one result; an in-order
// ordered word that releases a held run blocks input until the run is read out, one
// slot-store read per cycle, so results leave at one per cycle, all while pop is held.
// Reset: synchronous rst_n clears channel indices, ring heads and slot occupancy;
// the slot handle store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// ordered_sequenced_reorder_buffer
// Per-channel packet reorder buffer with unordered, sequenced and ordered modes.
// ----------------------------------------------------------------------------
module ordered_sequenced_reorder_buffer import osrb_pkg::*; #(
  parameter int CHANNELS    = OSRB_CHANNELS,
  parameter int WINDOW      = OSRB_WINDOW,
  parameter int HANDLE_BITS = OSRB_HANDLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [HANDLE_W-1:0]     in_handle,
  input  logic [CHAN_FIELD_W-1:0] in_channel,
  input  logic [INDEX_W-1:0]      in_order_index,
  input  logic [MODE_W-1:0]       in_mode,
  output logic                    empty,
  input  logic                    pop,
  output logic [HANDLE_W-1:0]     out_handle,
  output logic [KIND_W-1:0]       out_kind,
  output logic [CHAN_FIELD_W-1:0] out_channel,
  output logic                    out_last
);

  logic cmd_push, q_full, q_valid, q_take;
  cmd_t cmd, q_data;

  osrb_front #(
    .CHANNELS    (CHANNELS),
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_handle      (in_handle),
    .in_channel     (in_channel),
    .in_order_index (in_order_index),
    .in_mode        (in_mode),
    .cmd_push       (cmd_push),
    .cmd            (cmd),
    .q_full         (q_full)
  );

  osrb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_en   (q_take),
    .rd_data (q_data)
  );

  osrb_back #(
    .CHANNELS    (CHANNELS),
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_take      (q_take),
    .empty       (empty),
    .pop         (pop),
    .out_handle  (out_handle),
    .out_kind    (out_kind),
    .out_channel (out_channel),
    .out_last    (out_last)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reorder buffer testbench
// Drives packet words through the push/full side and drains results through
// the empty/pop side, both with random stalls. A scoreboard keeps its own copy
// of the per-channel indices and held slots. It predicts every result and
// checks each popped result against the oldest one still outstanding.
// ----------------------------------------------------------------------------
import osrb_pkg::*;

class reorder_scoreboard;
  localparam int HEAD_W = $clog2(OSRB_WINDOW);

  typedef struct {
    logic [HANDLE_W-1:0]     handle;
    kind_t                   kind;
    logic [CHAN_FIELD_W-1:0] channel;
    logic                    last;
  } result_t;

  result_t                 expected_q[$];
  logic [INDEX_W-1:0]      read_index   [OSRB_CHANNELS];
  logic [INDEX_W-1:0]      seq_expected [OSRB_CHANNELS];
  logic [HEAD_W-1:0]       ring_head    [OSRB_CHANNELS];
  logic [OSRB_WINDOW-1:0]  occupied     [OSRB_CHANNELS];
  logic [HANDLE_W-1:0]     held_handle  [OSRB_CHANNELS][OSRB_WINDOW];
  int                      failures;

  function new();
    foreach (read_index[c]) begin
      read_index[c]   = '0;
      seq_expected[c] = '0;
      ring_head[c]    = '0;
      occupied[c]     = '0;
    end
    failures = 0;
  endfunction

  function void add(logic [HANDLE_W-1:0] h, kind_t k, logic [CHAN_FIELD_W-1:0] chf);
    result_t r;
    r.handle  = h;
    r.kind    = k;
    r.channel = chf;
    r.last    = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Work out every result that one accepted word causes.
  function void note_word(logic [HANDLE_W-1:0] h, logic [CHAN_FIELD_W-1:0] chf,
                          logic [INDEX_W-1:0] idx, logic [MODE_W-1:0] mode);
    int                 ch;
    logic [INDEX_W-1:0] off;
    logic [HEAD_W-1:0]  s;
    result_t            tail;
    ch = chf % OSRB_CHANNELS;
    case (mode)
      MODE_SEQUENCED: begin
        if (idx >= seq_expected[ch]) begin
          seq_expected[ch] = idx + 1;
          add(h, KIND_DELIVERED, chf);
        end else begin
          add(h, KIND_LATE, chf);
        end
      end
      MODE_ORDERED: begin
        off = idx - read_index[ch];
        if (idx < read_index[ch]) begin
          add(h, KIND_LATE, chf);
        end else if (off >= OSRB_WINDOW) begin
          add(h, KIND_DROPPED, chf);
        end else if (off == 0) begin
          add(h, KIND_DELIVERED, chf);
          read_index[ch]++;
          ring_head[ch]++;
          // release the contiguous held run, stopping at the first gap
          for (int i = 1; i < OSRB_WINDOW; i++) begin
            if (!occupied[ch][ring_head[ch]]) break;
            add(held_handle[ch][ring_head[ch]], KIND_DELIVERED, chf);
            occupied[ch][ring_head[ch]] = 1'b0;
            read_index[ch]++;
            ring_head[ch]++;
          end
        end else begin
          s = ring_head[ch] + off[HEAD_W-1:0];
          if (occupied[ch][s]) begin
            add(h, KIND_LATE, chf);
          end else begin
            held_handle[ch][s] = h;
            occupied[ch][s]    = 1'b1;
            add(h, KIND_HELD, chf);
          end
        end
      end
      default: add(h, KIND_DELIVERED, chf);  // unordered and the spare mode code
    endcase
    tail      = expected_q.pop_back();
    tail.last = 1'b1;
    expected_q.insert(expected_q.size(), tail);
  endfunction

  function void check_result(logic [HANDLE_W-1:0] h, logic [KIND_W-1:0] k,
                             logic [CHAN_FIELD_W-1:0] chf, logic lst);
    result_t want;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: unexpected result handle %h kind %0d chan %0d last %b",
                 h, k, chf, lst);
      return;
    end
    want = expected_q.pop_front();
    if (want.handle !== h || want.kind !== k || want.channel !== chf || want.last !== lst) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected handle %h kind %0d chan %0d last %b, got %h %0d %0d %b",
                 want.handle, want.kind, want.channel, want.last, h, k, chf, lst);
    end
  endfunction
endclass

module tb;
  localparam int                CYCLE_LIMIT   = 200000;
  localparam int                RANDOM_WORDS  = 180;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    push           = 1'b0;
  logic                    pop            = 1'b0;
  logic [HANDLE_W-1:0]     in_handle      = '0;
  logic [CHAN_FIELD_W-1:0] in_channel     = '0;
  logic [INDEX_W-1:0]      in_order_index = '0;
  logic [MODE_W-1:0]       in_mode        = '0;
  logic                    full;
  logic                    empty;
  logic [HANDLE_W-1:0]     out_handle;
  logic [KIND_W-1:0]       out_kind;
  logic [CHAN_FIELD_W-1:0] out_channel;
  logic                    out_last;

  reorder_scoreboard sb;
  int                idle_pct    = 37;
  int                words_sent  = 0;
  int                cycle_count = 0;

  ordered_sequenced_reorder_buffer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_handle      (in_handle),
    .in_channel     (in_channel),
    .in_order_index (in_order_index),
    .in_mode        (in_mode),
    .empty          (empty),
    .pop            (pop),
    .out_handle     (out_handle),
    .out_kind       (out_kind),
    .out_channel    (out_channel),
    .out_last       (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_result(out_handle, out_kind, out_channel, out_last);
  end

  task automatic send_word(logic [HANDLE_W-1:0] h, logic [CHAN_FIELD_W-1:0] chf,
                           logic [INDEX_W-1:0] idx, logic [MODE_W-1:0] mode);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_handle      <= h;
    in_channel     <= chf;
    in_order_index <= idx;
    in_mode        <= mode;
    do @(posedge clk); while (full);
    sb.note_word(h, chf, idx, mode);
    words_sent++;
  endtask

  // Ordered word that is late, lands inside the window, lands beyond it, or is random.
  task automatic send_ordered_noise(logic [CHAN_FIELD_W-1:0] chf);
    logic [INDEX_W-1:0] rd;
    logic [INDEX_W-1:0] idx;
    rd = sb.read_index[chf];
    case ($urandom_range(3))
      0:       idx = rd - 1 - $urandom_range(7);
      1:       idx = rd + $urandom_range(31, 1);
      2:       idx = rd + OSRB_WINDOW + $urandom_range(200);
      default: idx = $urandom;
    endcase
    send_word(HANDLE_W'($urandom_range(16'hFFFF)), chf, idx, MODE_ORDERED);
  endtask

  // A well-formed window of ordered words in shuffled order. With
  // zero_last the in-order word comes last, so the whole window drains at once.
  task automatic ordered_burst(logic [CHAN_FIELD_W-1:0] chf, int len, bit zero_last);
    logic [INDEX_W-1:0] base;
    int                 offs[OSRB_WINDOW];
    int                 top;
    int                 j;
    int                 tmp;
    base = sb.read_index[chf];
    for (int k = 0; k < len; k++) offs[k] = zero_last ? (k + 1) % len : k;
    top = zero_last ? len - 2 : len - 1;
    for (int k = top; k > 0; k--) begin
      j       = $urandom_range(k);
      tmp     = offs[k];
      offs[k] = offs[j];
      offs[j] = tmp;
    end
    for (int k = 0; k < len; k++) begin
      if (!zero_last && $urandom_range(99) < 10) send_ordered_noise(chf);
      send_word(HANDLE_W'($urandom_range(16'hFFFF)), chf, base + offs[k], MODE_ORDERED);
    end
  endtask

  task automatic sequenced_burst(logic [CHAN_FIELD_W-1:0] chf, int n);
    logic [INDEX_W-1:0] e;
    logic [INDEX_W-1:0] idx;
    int                 r;
    repeat (n) begin
      e = sb.seq_expected[chf];
      r = $urandom_range(99);
      if (r < 65)      idx = e + $urandom_range(3);
      else if (r < 85) idx = e - 1 - $urandom_range(4);  // late, or wraps at zero
      else             idx = $urandom;
      send_word(HANDLE_W'($urandom_range(16'hFFFF)), chf, idx, MODE_SEQUENCED);
    end
  endtask

  initial begin
    int target;
    int r;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    send_word(16'h0000, 3'd0, 32'h0000_0000, MODE_UNORDERED);
    send_word(16'hFFFF, 3'd7, 32'hFFFF_FFFF, MODE_UNORDERED);
    send_word(16'h1234, 3'd5, 32'h0000_0007, MODE_RESERVED);
    send_word(16'h0101, 3'd1, 32'h0000_0000, MODE_SEQUENCED);
    send_word(16'h0102, 3'd1, 32'h0000_0000, MODE_SEQUENCED);
    send_word(16'h0103, 3'd1, 32'h0000_000A, MODE_SEQUENCED);
    send_word(16'h0104, 3'd1, 32'hFFFF_FFFF, MODE_SEQUENCED);
    send_word(16'h0105, 3'd1, 32'h0000_0000, MODE_SEQUENCED);
    send_word(16'h0201, 3'd2, 32'h0000_0000, MODE_ORDERED);
    send_word(16'h0202, 3'd2, 32'h0000_0003, MODE_ORDERED);
    send_word(16'h0203, 3'd2, 32'h0000_0002, MODE_ORDERED);
    send_word(16'h0204, 3'd2, 32'h0000_0003, MODE_ORDERED);  // slot taken
    send_word(16'h0205, 3'd2, 32'h0000_0020, MODE_ORDERED);  // far edge of window
    send_word(16'h0206, 3'd2, 32'h0000_0021, MODE_ORDERED);  // just past it
    send_word(16'h0207, 3'd2, 32'hFFFF_FFFF, MODE_ORDERED);
    send_word(16'h0208, 3'd2, 32'h0000_0000, MODE_ORDERED);  // already released
    send_word(16'h0209, 3'd2, 32'h0000_0001, MODE_ORDERED);  // drains 1..3
    send_word(16'h020A, 3'd2, 32'h0000_0004, MODE_ORDERED);
    send_word(16'h0701, 3'd7, 32'h0000_0001, MODE_ORDERED);
    send_word(16'h0702, 3'd7, 32'h0000_0000, MODE_ORDERED);
    send_word(16'h0601, 3'd6, 32'h0000_0005, MODE_ORDERED);

    // random part: one full-window drain first, then mixed traffic
    target = words_sent + RANDOM_WORDS;
    ordered_burst(3'd3, OSRB_WINDOW, 1'b1);
    while (words_sent < target) begin
      idle_pct = (words_sent >= 110 && words_sent < 170) ? 0 : 37;
      r = $urandom_range(99);
      if (r < 55) begin
        if ($urandom_range(99) < 80)
          ordered_burst(CHAN_FIELD_W'($urandom_range(7)), $urandom_range(8, 1), 1'b0);
        else
          ordered_burst(CHAN_FIELD_W'($urandom_range(7)), $urandom_range(OSRB_WINDOW, 9),
                        1'($urandom_range(1)));
      end else if (r < 75) begin
        sequenced_burst(CHAN_FIELD_W'($urandom_range(7)), $urandom_range(6, 1));
      end else if (r < 85) begin
        send_word(HANDLE_W'($urandom_range(16'hFFFF)), CHAN_FIELD_W'($urandom_range(7)),
                  $urandom, MODE_UNORDERED);
      end else if (r < 90) begin
        send_word(HANDLE_W'($urandom_range(16'hFFFF)), CHAN_FIELD_W'($urandom_range(7)),
                  $urandom, MODE_RESERVED);
      end else begin
        send_ordered_noise(CHAN_FIELD_W'($urandom_range(7)));
      end
    end
    push <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/osrb_pkg.sv
rtl/osrb_front.sv
rtl/osrb_queue.sv
rtl/osrb_back.sv
rtl/ordered_sequenced_reorder_buffer.sv
tb/tb.sv
